// ===== rtl/tla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_pkg: shared types and constants for the two-limit thermostat alarm
// Holds the action and mode codes, the boot limits and the limit edit
// request that the top level passes to the limit editor.
// ----------------------------------------------------------------------------
package tla_pkg;

  // Width of one temperature or limit value.
  localparam int unsigned TempW = 7;

  // Limits loaded at reset.
  localparam logic [TempW-1:0] UPPER_BOOT = 7'd30;
  localparam logic [TempW-1:0] LOWER_BOOT = 7'd20;

  // Input action codes.
  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SAMPLE = 3'd1,
    ACT_SET    = 3'd2,
    ACT_UP     = 3'd3,
    ACT_DOWN   = 3'd4
  } action_t;

  // Operating mode codes.
  typedef enum logic [1:0] {
    MODE_RUN        = 2'd0,
    MODE_EDIT_UPPER = 2'd1,
    MODE_EDIT_LOWER = 2'd2
  } mode_t;

  // Request to step one of the limits by one.
  typedef struct packed {
    logic sel_upper;
    logic sel_lower;
    logic inc;
  } edit_req_t;

endpackage

// ===== rtl/two_limit_thermostat_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_limit_thermostat_alarm: bang-bang thermostat with high and low alarm
// Takes ticks, temperature samples and set, up and down key presses, and
// returns one result item with relay, buzzer, mode and limit state for each.
// ----------------------------------------------------------------------------
// The block accepts one item in every clock cycle while in_ready is high and
// returns exactly one result item for each, in the cycle after acceptance,
// from a single output register. All state update is done in compare and
// add logic ahead of that register. in_ready is high whenever the output
// register is empty or its result is taken in the same cycle, so a stalled
// output holds the input side and the state together. The beeper toggles
// every TICKS_PER_TOGGLE tick items while an alarm holds; limits wrap above
// LIMIT_MAX to zero, and the upper limit is then kept above the lower.
module two_limit_thermostat_alarm
  import tla_pkg::*;
#(
  parameter int unsigned TICKS_PER_TOGGLE = 10,
  parameter int unsigned LIMIT_MAX        = 99
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       action,
  input  logic [TempW-1:0] temperature,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             fan_on,
  output logic             heater_on,
  output logic             beep_on,
  output logic [1:0]       edit_mode,
  output logic [TempW-1:0] upper_value,
  output logic [TempW-1:0] lower_value,
  output logic             commit
);

  localparam int unsigned TickW = (TICKS_PER_TOGGLE > 1) ? $clog2(TICKS_PER_TOGGLE) : 1;
  localparam logic [TickW:0] TicksW = (TickW + 1)'(TICKS_PER_TOGGLE);

  // State registers; the relay, mode and limit registers also drive the
  // result ports, since state only moves when the previous result is taken.
  mode_t            mode, mode_next;
  logic [TempW-1:0] upper_limit, upper_limit_next;
  logic [TempW-1:0] lower_limit, lower_limit_next;
  logic             beep_timer_run, beep_timer_run_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic             beep_phase, beep_phase_next;
  logic             fan_bit, fan_bit_next;
  logic             heater_bit, heater_bit_next;
  logic             beep_bit, beep_bit_next;
  logic             commit_next;

  logic             accept;
  logic [TickW:0]   tick_sum;
  logic             high_alarm;
  logic             low_alarm;
  edit_req_t        edit_req;
  logic [TempW-1:0] upper_edit;
  logic [TempW-1:0] lower_edit;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Alarm compares against the current limits.
  assign high_alarm = upper_limit < temperature;
  assign low_alarm  = lower_limit > temperature;
  assign tick_sum   = {1'b0, tick_count} + 1'b1;

  // Limit edit request from the key and the mode.
  always_comb begin
    edit_req.inc       = (action_t'(action) == ACT_UP);
    edit_req.sel_upper = ((action_t'(action) == ACT_UP) || (action_t'(action) == ACT_DOWN))
                         && (mode == MODE_EDIT_UPPER);
    edit_req.sel_lower = ((action_t'(action) == ACT_UP) || (action_t'(action) == ACT_DOWN))
                         && (mode == MODE_EDIT_LOWER);
  end

  tla_limit_edit #(
    .LIMIT_MAX(LIMIT_MAX)
  ) u_limit_edit (
    .req        (edit_req),
    .upper_limit(upper_limit),
    .lower_limit(lower_limit),
    .upper_next (upper_edit),
    .lower_next (lower_edit)
  );

  // Next state for one item.
  always_comb begin
    mode_next           = mode;
    upper_limit_next    = upper_limit;
    lower_limit_next    = lower_limit;
    beep_timer_run_next = beep_timer_run;
    tick_count_next     = tick_count;
    beep_phase_next     = beep_phase;
    fan_bit_next        = fan_bit;
    heater_bit_next     = heater_bit;
    beep_bit_next       = beep_bit;
    commit_next         = 1'b0;
    unique case (action_t'(action))
      ACT_TICK: begin
        if (beep_timer_run) begin
          if (tick_sum >= TicksW) begin
            tick_count_next = '0;
            beep_phase_next = !beep_phase;
          end else begin
            tick_count_next = tick_sum[TickW-1:0];
          end
          if (mode == MODE_RUN) begin
            beep_bit_next = beep_phase_next;
          end
        end
      end
      ACT_SAMPLE: begin
        if (mode == MODE_RUN) begin
          if (high_alarm || low_alarm) begin
            beep_timer_run_next = 1'b1;
            beep_bit_next       = beep_phase;
          end else begin
            beep_timer_run_next = 1'b0;
            fan_bit_next        = 1'b0;
            heater_bit_next     = 1'b0;
            beep_bit_next       = 1'b0;
          end
          if (high_alarm) begin
            fan_bit_next = 1'b1;
          end
          if (low_alarm) begin
            heater_bit_next = 1'b1;
          end
        end
      end
      ACT_SET: begin
        unique case (mode)
          MODE_RUN:        mode_next = MODE_EDIT_UPPER;
          MODE_EDIT_UPPER: mode_next = MODE_EDIT_LOWER;
          default: begin
            mode_next   = MODE_RUN;
            commit_next = 1'b1;
          end
        endcase
      end
      ACT_UP, ACT_DOWN: begin
        upper_limit_next = upper_edit;
        lower_limit_next = lower_edit;
      end
      default: begin
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      mode           <= MODE_RUN;
      upper_limit    <= UPPER_BOOT;
      lower_limit    <= LOWER_BOOT;
      beep_timer_run <= 1'b0;
      tick_count     <= '0;
      beep_phase     <= 1'b1;
      fan_bit        <= 1'b0;
      heater_bit     <= 1'b0;
      beep_bit       <= 1'b0;
    end else begin
      if (accept) begin
        out_valid      <= 1'b1;
        mode           <= mode_next;
        upper_limit    <= upper_limit_next;
        lower_limit    <= lower_limit_next;
        beep_timer_run <= beep_timer_run_next;
        tick_count     <= tick_count_next;
        beep_phase     <= beep_phase_next;
        fan_bit        <= fan_bit_next;
        heater_bit     <= heater_bit_next;
        beep_bit       <= beep_bit_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Commit pulse belongs to the result item only.
  always_ff @(posedge clk) begin
    if (accept) begin
      commit <= commit_next;
    end
  end

  assign fan_on      = fan_bit;
  assign heater_on   = heater_bit;
  assign beep_on     = beep_bit;
  assign edit_mode   = mode;
  assign upper_value = upper_limit;
  assign lower_value = lower_limit;

  // The upper limit always stays strictly above the lower limit.
  a_limit_order: assert property (@(posedge clk) disable iff (rst)
    upper_limit > lower_limit)
    else $error("upper limit not above lower limit");

  // The beeper never sounds without a relay on.
  a_beep_with_relay: assert property (@(posedge clk) disable iff (rst)
    beep_bit |-> (fan_bit || heater_bit))
    else $error("beeper on with both relays off");

  // A commit result always reports run mode.
  a_commit_in_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && commit) |-> (mode == MODE_RUN))
    else $error("commit outside run mode");

  // The tick counter stays below the toggle period.
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, tick_count} < TicksW) || (TICKS_PER_TOGGLE == 1))
    else $error("tick counter out of range");

endmodule

// ===== rtl/tla_limit_edit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_limit_edit: limit stepping logic
// Steps the selected limit up or down by one, wraps past the maximum to
// zero and keeps the upper limit strictly above the lower limit.
// ----------------------------------------------------------------------------
module tla_limit_edit
  import tla_pkg::*;
#(
  parameter int unsigned LIMIT_MAX = 99
) (
  input  edit_req_t        req,
  input  logic [TempW-1:0] upper_limit,
  input  logic [TempW-1:0] lower_limit,
  output logic [TempW-1:0] upper_next,
  output logic [TempW-1:0] lower_next
);

  localparam logic [TempW:0] LimitMaxW = (TempW + 1)'(LIMIT_MAX);

  logic [TempW:0] upper_ext;
  logic [TempW:0] lower_ext;
  logic [TempW:0] upper_step;
  logic [TempW:0] lower_step;

  assign upper_ext = {1'b0, upper_limit};
  assign lower_ext = {1'b0, lower_limit};

  // Upper limit: step, wrap above the maximum, then stay above the lower.
  always_comb begin
    upper_step = req.inc ? upper_ext + 1'b1 : upper_ext - 1'b1;
    if (upper_step > LimitMaxW) begin
      upper_step = '0;
    end
    if (upper_step <= lower_ext) begin
      upper_step = lower_ext + 1'b1;
    end
    upper_next = req.sel_upper ? upper_step[TempW-1:0] : upper_limit;
  end

  // Lower limit: step, wrap above the maximum, then stay below the upper.
  always_comb begin
    lower_step = req.inc ? lower_ext + 1'b1 : lower_ext - 1'b1;
    if (lower_step > LimitMaxW) begin
      lower_step = '0;
    end
    if (upper_ext <= lower_step) begin
      lower_step = upper_ext - 1'b1;
    end
    lower_next = req.sel_lower ? lower_step[TempW-1:0] : lower_limit;
  end

endmodule
